[rtl/core/gtg_pkg.sv]
package gtg_pkg;

	localparam int CordicStagesDefault = 16;

	// datapath widths
	localparam int CW = 46;   // cordic x/y width (signed)
	localparam int ZW = 28;   // cordic angle width (signed, Q24)

	localparam logic signed [ZW-1:0] ANG_PI  = 28'sd52707179;
	localparam logic signed [ZW-1:0] ANG_2PI = 28'sd105414358;
	localparam logic signed [15:0] ERR_LIMIT = 16'sd25736;
	localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

	// register indexes
	localparam logic [2:0] REG_LIN_GAIN  = 3'd0;
	localparam logic [2:0] REG_ANG_GAIN  = 3'd1;
	localparam logic [2:0] REG_MAX_LIN   = 3'd2;
	localparam logic [2:0] REG_MAX_ANG   = 3'd3;
	localparam logic [2:0] REG_ARRIVE    = 3'd4;
	localparam logic [2:0] REG_ALIGN     = 3'd5;

	typedef struct packed {
		logic [15:0] linear_gain;
		logic [15:0] angular_gain;
		logic [15:0] max_linear_speed;
		logic [15:0] max_angular_speed;
		logic [30:0] arrive_distance;
		logic [14:0] turn_cut_angle;
	} cfg_t;

	// one vectoring lane of the cordic chain
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} lane_t;

	function automatic logic signed [ZW-1:0] atan_entry(input int i);
		logic signed [ZW-1:0] r;
		unique case (i)
			0: r = 28'sd13176795;
			1: r = 28'sd7778716;
			2: r = 28'sd4110060;
			3: r = 28'sd2086331;
			4: r = 28'sd1047214;
			5: r = 28'sd524117;
			6: r = 28'sd262123;
			7: r = 28'sd131069;
			8: r = 28'sd65536;
			9: r = 28'sd32768;
			default: r = (i <= 24) ? ZW'(28'sd1 <<< (24 - i)) : '0;
		endcase
		return r;
	endfunction

endpackage

[rtl/core/gtg_if.sv]
interface gtg_in_if;
	logic valid;
	logic ready;
	logic signed [30:0] pose_x;
	logic signed [30:0] pose_y;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;
	logic signed [15:0] quat_w;
	logic signed [30:0] goal_x;
	logic signed [30:0] goal_y;
	logic have_goal;
	logic have_pose;
	modport source (output valid, pose_x, pose_y, quat_x, quat_y, quat_z, quat_w,
		goal_x, goal_y, have_goal, have_pose, input ready);
	modport sink (input valid, pose_x, pose_y, quat_x, quat_y, quat_z, quat_w,
		goal_x, goal_y, have_goal, have_pose, output ready);
endinterface

interface gtg_out_if;
	logic valid;
	logic ready;
	logic [15:0] linear_cmd;
	logic signed [16:0] angular_cmd;
	logic reached;
	modport source (output valid, linear_cmd, angular_cmd, reached, input ready);
	modport sink (input valid, linear_cmd, angular_cmd, reached, output ready);
endinterface

interface gtg_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [30:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/gtg_cordic_cell.sv]
module gtg_cordic_cell #(
	parameter int STAGE = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_in,
	input  gtg_pkg::lane_t yaw_in,
	input  gtg_pkg::lane_t brg_in,
	output logic vld_out,
	output gtg_pkg::lane_t yaw_out,
	output gtg_pkg::lane_t brg_out
);
	import gtg_pkg::*;

	localparam int SH = (STAGE < CW - 1) ? STAGE : CW - 1;
	localparam logic signed [ZW-1:0] ATAN = atan_entry(STAGE);

	function automatic lane_t rot(input lane_t a);
		lane_t r;
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		xs = a.x >>> SH;
		ys = a.y >>> SH;
		// a zero vector keeps its zero angle
		if (a.x == '0 && a.y == '0) begin
			r = a;
		end else if (!a.y[CW-1]) begin
			r.x = a.x + ys; r.y = a.y - xs; r.z = a.z + ATAN;
		end else begin
			r.x = a.x - ys; r.y = a.y + xs; r.z = a.z - ATAN;
		end
		return r;
	endfunction

	// one micro-rotation per lane, handed to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yaw_out <= rot(yaw_in);
			brg_out <= rot(brg_in);
		end
	end
endmodule

[rtl/core/gtg_post.sv]
module gtg_post (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_in,
	input  gtg_pkg::lane_t yaw_in,
	input  gtg_pkg::lane_t brg_in,
	input  gtg_pkg::cfg_t cfg,
	output logic vld_out,
	output logic [15:0] linear_cmd,
	output logic signed [16:0] angular_cmd,
	output logic reached
);
	import gtg_pkg::*;

	// reciprocal of 5, exact as (n * DIV5_MUL) >> 34 for any 32-bit n
	localparam logic [31:0] DIV5_MUL = 32'hCCCCCCCD;

	// stage 1: gain-scaled magnitude and wrapped, rounded heading error
	logic vld_s1, vld_s2, vld_s3;
	logic [37:0] mag_s1;
	logic signed [ZW:0] err_s1;
	logic [67:0] dprod_s2;
	logic signed [15:0] err_s2;
	logic [31:0] dist_s3;
	logic signed [15:0] err_s3;
	logic [47:0] v28_s4;
	logic signed [32:0] w25_s4;
	logic near_s4, cut_s4, vld_s4;
	logic signed [ZW:0] e_wrap;
	logic signed [ZW:0] e_rnd;
	logic signed [15:0] e_sat;
	logic [15:0] e_abs;
	logic cut_w;
	logic [31:0] v12q;
	logic [63:0] v12m;
	logic [31:0] v12w;
	logic signed [32:0] w12w;
	logic signed [16:0] lim;

	function automatic logic signed [ZW:0] e_rnd_in(input logic signed [ZW:0] e);
		return (e + (ZW+1)'(1024)) >>> 11;
	endfunction

	always_comb begin
		e_wrap = (ZW+1)'(brg_in.z) - (ZW+1)'(yaw_in.z);
		if (e_wrap > (ZW+1)'(ANG_PI)) e_wrap = e_wrap - (ZW+1)'(ANG_2PI);
		else if (e_wrap < -(ZW+1)'(ANG_PI)) e_wrap = e_wrap + (ZW+1)'(ANG_2PI);
		e_rnd = (e_rnd_in(e_wrap));
	end

	always_comb begin
		if (err_s1 > (ZW+1)'(ERR_LIMIT)) e_sat = ERR_LIMIT;
		else if (err_s1 < -(ZW+1)'(ERR_LIMIT)) e_sat = -ERR_LIMIT;
		else e_sat = err_s1[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0; vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in; vld_s2 <= vld_s1; vld_s3 <= vld_s2; vld_s4 <= vld_s3;
		end
	end

	assign e_abs = err_s3[15] ? 16'(-err_s3) : err_s3;
	assign cut_w = e_abs > 16'(cfg.turn_cut_angle);

	always_ff @(posedge clk) begin
		if (en) begin
			// magnitude truncated to Q16.16, error wrapped and rounded
			mag_s1   <= 38'(brg_in.x >>> 8);
			err_s1   <= e_rnd;
			dprod_s2 <= 68'(mag_s1) * 68'(INV_GAIN_Q30) + 68'(1 << 29);
			err_s2   <= e_sat;
			dist_s3  <= dprod_s2[61:30];
			err_s3   <= err_s2;
			// gains and compare, rounding bias folded in (five halves when cut)
			v28_s4   <= 48'(cfg.linear_gain) * 48'(dist_s3) +
				(cut_w ? 48'd163840 : 48'd32768);
			w25_s4   <= $signed({17'b0, cfg.angular_gain}) * 33'(err_s3);
			near_s4  <= {1'b0, dist_s3} < 33'(cfg.arrive_distance);
			cut_s4   <= cut_w;
		end
	end

	// stage 5: cut, round and clamp
	always_comb begin
		v12q = v28_s4[47:16];
		v12m = 64'(v12q) * 64'(DIV5_MUL);
		v12w = cut_s4 ? 32'(v12m >> 34) : v12q;
		w12w = (w25_s4 + 33'sd4096) >>> 13;
		lim = $signed({1'b0, cfg.max_angular_speed});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			reached <= near_s4;
			if (near_s4) begin
				linear_cmd <= '0;
				angular_cmd <= '0;
			end else begin
				linear_cmd <= (v12w > 32'(cfg.max_linear_speed)) ?
					cfg.max_linear_speed : v12w[15:0];
				if (w12w > 33'(lim)) angular_cmd <= lim;
				else if (w12w < -33'(lim)) angular_cmd <= -lim;
				else angular_cmd <= w12w[16:0];
			end
		end
	end
endmodule

[rtl/core/go_to_goal_velocity_controller.sv]
// channel  dir  handshake    payload
// in       in   valid/ready  pose, quaternion, goal, flags
// out      out  valid/ready  linear_cmd, angular_cmd, reached
// cfg      in   valid/ready  index, data
// one item a cycle while the output is not stalled; items pass through the
// prerotation registers, the chain of cordic cells and the scaling stages
// the whole chain advances together and stops when the output register is full
// and not taken; items with a missing flag drop out at entry
// reset loads the register defaults and empties the chain
module go_to_goal_velocity_controller #(
	parameter int CORDIC_STAGES = gtg_pkg::CordicStagesDefault
) (
	input logic clk,
	input logic arst_n,
	gtg_in_if.sink  in_ch,
	gtg_out_if.source out_ch,
	gtg_cfg_if.sink cfg_ch
);
	import gtg_pkg::*;

	cfg_t cfg_q;
	logic en;
	logic signed [33:0] num, den;
	logic signed [CW-1:0] dx, dy;
	lane_t yaw0, brg0;
	logic pre_vld_s1, pre_vld_s2;
	logic signed [33:0] qa_s1, qb_s1, qc_s1, qd_s1;
	logic signed [31:0] dx_s1, dy_s1;
	lane_t yaw_s2, brg_s2;
	logic vld_c [CORDIC_STAGES+1];
	lane_t yaw_c [CORDIC_STAGES+1];
	lane_t brg_c [CORDIC_STAGES+1];
	logic [15:0] lin_w;
	logic signed [16:0] ang_w;
	logic rch_w, vld_w;

	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;
	assign cfg_ch.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{16'd3277, 16'd10240, 16'd3277, 16'd4915, 31'd16384, 15'd4915};
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				REG_LIN_GAIN: cfg_q.linear_gain <= cfg_ch.data[15:0];
				REG_ANG_GAIN: cfg_q.angular_gain <= cfg_ch.data[15:0];
				REG_MAX_LIN:  cfg_q.max_linear_speed <= cfg_ch.data[15:0];
				REG_MAX_ANG:  cfg_q.max_angular_speed <= cfg_ch.data[15:0];
				REG_ARRIVE:   cfg_q.arrive_distance <= cfg_ch.data;
				REG_ALIGN:    cfg_q.turn_cut_angle <= cfg_ch.data[14:0];
				default: ;
			endcase
		end
	end

	// quaternion products and position deltas
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_vld_s1 <= 1'b0; pre_vld_s2 <= 1'b0;
		end else if (en) begin
			pre_vld_s1 <= in_ch.valid && in_ch.have_goal && in_ch.have_pose;
			pre_vld_s2 <= pre_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qa_s1 <= 34'(in_ch.quat_w * in_ch.quat_z);
			qb_s1 <= 34'(in_ch.quat_x * in_ch.quat_y);
			qc_s1 <= 34'(in_ch.quat_y * in_ch.quat_y);
			qd_s1 <= 34'(in_ch.quat_z * in_ch.quat_z);
			dx_s1 <= 32'(in_ch.goal_x) - 32'(in_ch.pose_x);
			dy_s1 <= 32'(in_ch.goal_y) - 32'(in_ch.pose_y);
		end
	end

	// prerotation into the right half plane
	function automatic lane_t prerot(input logic signed [CW-1:0] x,
		input logic signed [CW-1:0] y);
		lane_t r;
		r.x = x; r.y = y; r.z = '0;
		if (x[CW-1]) begin
			r.x = -x; r.y = -y;
			r.z = y[CW-1] ? -ANG_PI : ANG_PI;
		end
		return r;
	endfunction

	always_comb begin
		num = (qa_s1 + qb_s1) <<< 1;
		den = 34'sd268435456 - ((qc_s1 + qd_s1) <<< 1);
		dx = CW'(dx_s1) <<< 8;
		dy = CW'(dy_s1) <<< 8;
		yaw0 = prerot(CW'(den), CW'(num));
		brg0 = prerot(dx, dy);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yaw_s2 <= yaw0;
			brg_s2 <= brg0;
		end
	end

	assign vld_c[0] = pre_vld_s2;
	assign yaw_c[0] = yaw_s2;
	assign brg_c[0] = brg_s2;

	// chain of cordic cells
	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
		gtg_cordic_cell #(.STAGE(g)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(vld_c[g]), .yaw_in(yaw_c[g]), .brg_in(brg_c[g]),
			.vld_out(vld_c[g+1]), .yaw_out(yaw_c[g+1]), .brg_out(brg_c[g+1])
		);
	end

	gtg_post u_post (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(vld_c[CORDIC_STAGES]), .yaw_in(yaw_c[CORDIC_STAGES]),
		.brg_in(brg_c[CORDIC_STAGES]), .cfg(cfg_q),
		.vld_out(vld_w), .linear_cmd(lin_w), .angular_cmd(ang_w), .reached(rch_w)
	);

	assign out_ch.valid = vld_w;
	assign out_ch.linear_cmd = lin_w;
	assign out_ch.angular_cmd = ang_w;
	assign out_ch.reached = rch_w;

`ifndef SYNTHESIS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.linear_cmd))
		else $error("result changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready == (!out_ch.valid || out_ch.ready))
		else $error("input ready mismatch");
	a_reached_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.reached |-> out_ch.linear_cmd == 16'd0 &&
		out_ch.angular_cmd == 17'sd0)
		else $error("reached with speed");
	a_lin_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && $stable(cfg_q) |-> out_ch.linear_cmd <= cfg_q.max_linear_speed)
		else $error("linear clamp broken");
`endif
endmodule

[verif/tb_go_to_goal_velocity_controller.sv]
module tb_go_to_goal_velocity_controller;
	timeunit 1ns;
	timeprecision 1ps;
	import gtg_pkg::*;

	localparam int STAGES = CordicStagesDefault;
	localparam int DRAIN_CYCLES = STAGES + 8 + 16;
	localparam int CYCLE_LIMIT = 600000;
	localparam int LONG_HOLD = 400;
	localparam logic [2:0] REG_UNUSED = 3'd6;
	localparam longint PI_Q24 = 52707179;
	localparam longint TWO_PI_Q24 = 105414358;
	localparam longint ERR_SAT = 25736;
	localparam longint INV_K_Q30 = 652032874;

	typedef struct {
		logic signed [30:0] px, py;
		logic signed [15:0] qx, qy, qz, qw;
		logic signed [30:0] gx, gy;
		logic hg, hp;
	} pose_item_t;

	typedef struct {
		logic [15:0] lin;
		logic signed [16:0] ang;
		logic reached;
	} cmd_t;

	logic clk;
	logic arst_n;

	gtg_in_if in_ch ();
	gtg_out_if out_ch ();
	gtg_cfg_if cfg_ch ();

	go_to_goal_velocity_controller u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	// testbench copy of the registers
	longint unsigned lin_gain, ang_gain, lin_max, ang_max, arrive_dist, align_lim;

	pose_item_t pose_q[$];
	cmd_t cmd_q[$];
	pose_item_t on_bus;
	int fail_cnt = 0;
	int cycle_cnt = 0;
	int send_gap_max = 9;
	int recv_stall_max = 9;
	logic hold_req = 1'b0;

	// clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic longint atan_q24(int i);
		case (i)
			0: return 13176795;
			1: return 7778716;
			2: return 4110060;
			3: return 2086331;
			4: return 1047214;
			5: return 524117;
			6: return 262123;
			7: return 131069;
			8: return 65536;
			9: return 32768;
			default: return (i <= 24) ? (longint'(1) << (24 - i)) : 0;
		endcase
	endfunction

	// vectoring rotation: angle in Q24, gain-scaled magnitude
	function automatic longint vec_angle(longint x0, longint y0, output longint mag);
		longint x, y, z, xs, ys;
		x = x0;
		y = y0;
		z = 0;
		if (x == 0 && y == 0) begin
			mag = 0;
			return 0;
		end
		if (x < 0) begin
			z = (y >= 0) ? PI_Q24 : -PI_Q24;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys; y = y - xs; z = z + atan_q24(i);
			end else begin
				x = x - ys; y = y + xs; z = z - atan_q24(i);
			end
		end
		mag = x;
		return z;
	endfunction

	// steering command for one tick; returns 0 when no command is due
	function automatic bit steer_cmd(pose_item_t it, output cmd_t c);
		longint num, den, yaw, heading, err, mag, w12, lim;
		longint unsigned rng_v, v28, v12, aerr;
		c = '{default: '0};
		if (!it.hg || !it.hp)
			return 0;
		num = 2 * (longint'(it.qw) * it.qz + longint'(it.qx) * it.qy);
		den = (longint'(1) << 28) - 2 * (longint'(it.qy) * it.qy + longint'(it.qz) * it.qz);
		yaw = vec_angle(den, num, mag);
		heading = vec_angle((longint'(it.gx) - it.px) * 256,
			(longint'(it.gy) - it.py) * 256, mag);
		rng_v = longint'(mag >>> 8);
		rng_v = (rng_v * INV_K_Q30 + (longint'(1) << 29)) >> 30;
		if (rng_v < arrive_dist) begin
			c.reached = 1'b1;
			return 1;
		end
		err = heading - yaw;
		while (err > PI_Q24) err = err - TWO_PI_Q24;
		while (err < -PI_Q24) err = err + TWO_PI_Q24;
		err = (err + 1024) >>> 11;
		if (err > ERR_SAT) err = ERR_SAT;
		if (err < -ERR_SAT) err = -ERR_SAT;
		v28 = lin_gain * rng_v;
		aerr = (err < 0) ? -err : err;
		if (aerr > align_lim) v28 = v28 / 5;
		v12 = (v28 + (longint'(1) << 15)) >> 16;
		if (v12 > lin_max) v12 = lin_max;
		w12 = (longint'(ang_gain) * err + 4096) >>> 13;
		lim = longint'(ang_max);
		if (w12 > lim) w12 = lim;
		if (w12 < -lim) w12 = -lim;
		c.lin = v12[15:0];
		c.ang = w12[16:0];
		return 1;
	endfunction

	// item driver
	int gap_cnt;
	always @(posedge clk or negedge arst_n) begin
		cmd_t c;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.pose_x <= '0; in_ch.pose_y <= '0;
			in_ch.quat_x <= '0; in_ch.quat_y <= '0; in_ch.quat_z <= '0; in_ch.quat_w <= '0;
			in_ch.goal_x <= '0; in_ch.goal_y <= '0;
			in_ch.have_goal <= 1'b0; in_ch.have_pose <= 1'b0;
			gap_cnt <= 0;
		end else if (!(in_ch.valid && !in_ch.ready)) begin
			if (in_ch.valid && steer_cmd(on_bus, c))
				cmd_q.push_back(c);
			if (gap_cnt > 0) begin
				gap_cnt <= gap_cnt - 1;
				in_ch.valid <= 1'b0;
			end else if (pose_q.size() > 0) begin
				on_bus = pose_q.pop_front();
				in_ch.pose_x <= on_bus.px;
				in_ch.pose_y <= on_bus.py;
				in_ch.quat_x <= on_bus.qx;
				in_ch.quat_y <= on_bus.qy;
				in_ch.quat_z <= on_bus.qz;
				in_ch.quat_w <= on_bus.qw;
				in_ch.goal_x <= on_bus.gx;
				in_ch.goal_y <= on_bus.gy;
				in_ch.have_goal <= on_bus.hg;
				in_ch.have_pose <= on_bus.hp;
				in_ch.valid <= 1'b1;
				gap_cnt <= $urandom_range(0, send_gap_max);
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// result monitor and receiver stalls
	int wait_cnt, hold_cnt;
	logic hold_ack;
	always @(posedge clk or negedge arst_n) begin
		cmd_t e;
		int w;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			wait_cnt <= 0;
			hold_cnt <= 0;
			hold_ack <= 1'b0;
		end else begin
			w = $urandom_range(0, recv_stall_max);
			if (out_ch.valid && out_ch.ready) begin
				if (cmd_q.size() == 0) begin
					$error("result with no command waiting");
					fail_cnt++;
				end else begin
					e = cmd_q.pop_front();
					if (out_ch.linear_cmd !== e.lin) begin
						$error("linear_cmd expected %0d got %0d", e.lin, out_ch.linear_cmd);
						fail_cnt++;
					end
					if (out_ch.angular_cmd !== e.ang) begin
						$error("angular_cmd expected %0d got %0d", e.ang, out_ch.angular_cmd);
						fail_cnt++;
					end
					if (out_ch.reached !== e.reached) begin
						$error("reached expected %0b got %0b", e.reached, out_ch.reached);
						fail_cnt++;
					end
				end
			end
			if (hold_req != hold_ack) begin
				hold_ack <= hold_req;
				hold_cnt <= LONG_HOLD;
				out_ch.ready <= 1'b0;
			end else if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				out_ch.ready <= 1'b0;
			end else if (wait_cnt > 0) begin
				wait_cnt <= wait_cnt - 1;
				out_ch.ready <= 1'b0;
			end else if (out_ch.valid && out_ch.ready && w > 0) begin
				wait_cnt <= w - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [30:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_LIN_GAIN: lin_gain = val[15:0];
			REG_ANG_GAIN: ang_gain = val[15:0];
			REG_MAX_LIN: lin_max = val[15:0];
			REG_MAX_ANG: ang_max = val[15:0];
			REG_ARRIVE: arrive_dist = val[30:0];
			REG_ALIGN: align_lim = val[14:0];
			default: ;
		endcase
	endtask

	task automatic write_all(logic [15:0] lg, logic [15:0] ag, logic [15:0] lm,
		logic [15:0] am, logic [30:0] ad, logic [14:0] al);
		reg_write(REG_LIN_GAIN, {15'd0, lg});
		reg_write(REG_ANG_GAIN, {15'd0, ag});
		reg_write(REG_MAX_LIN, {15'd0, lm});
		reg_write(REG_MAX_ANG, {15'd0, am});
		reg_write(REG_ARRIVE, ad);
		reg_write(REG_ALIGN, {1'b0, al});
	endtask

	// wait for the block to go idle
	task automatic drain();
		do @(posedge clk); while (pose_q.size() > 0 || in_ch.valid);
		while (cmd_q.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic void add_pose(longint px, longint py, int qx, int qy, int qz,
		int qw, longint gx, longint gy, bit hg = 1, bit hp = 1);
		pose_item_t it;
		it.px = px[30:0]; it.py = py[30:0];
		it.qx = qx[15:0]; it.qy = qy[15:0]; it.qz = qz[15:0]; it.qw = qw[15:0];
		it.gx = gx[30:0]; it.gy = gy[30:0];
		it.hg = hg; it.hp = hp;
		pose_q.push_back(it);
	endfunction

	function automatic int srange(int r);
		return int'($urandom_range(0, 2 * r)) - r;
	endfunction

	// random tick: mostly plausible poses near the goal, some full-width noise
	function automatic void add_random_pose();
		pose_item_t it;
		int sel, span, c, s;
		sel = $urandom_range(0, 9);
		it.px = 31'($urandom());
		it.py = 31'($urandom());
		if (sel < 6) begin
			span = (sel < 3) ? 40000 : 3000000;
			it.gx = 31'(it.px + srange(span));
			it.gy = 31'(it.py + srange(span));
		end else begin
			it.gx = 31'($urandom());
			it.gy = 31'($urandom());
		end
		if (sel < 7) begin
			c = srange(16384);
			s = $urandom_range(0, 16384);
			it.qx = 16'(srange(600)); it.qy = 16'(srange(600));
			it.qz = 16'(c); it.qw = 16'((c < 0) ? -s : s);
		end else begin
			it.qx = 16'($urandom()); it.qy = 16'($urandom());
			it.qz = 16'($urandom()); it.qw = 16'($urandom());
		end
		it.hg = ($urandom_range(0, 9) != 0);
		it.hp = ($urandom_range(0, 9) != 0);
		pose_q.push_back(it);
	endfunction

	task automatic random_phase(int n);
		repeat (n) add_random_pose();
		drain();
	endtask

	initial begin
		cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
		arst_n = 1'b0;
		lin_gain = 3277; ang_gain = 10240; lin_max = 3277; ang_max = 4915;
		arrive_dist = 16384; align_lim = 4915;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed ticks with reset defaults
		add_pose(0, 0, 0, 0, 0, 16384, 65536, 0);
		add_pose(0, 0, 0, 0, 16384, 0, 65536, 0);
		add_pose(0, 0, 0, 0, 0, -16384, -65536, 65536);
		add_pose(1000, 1000, 0, 0, 0, 16384, 1000, 1000);
		add_pose(0, 0, 0, 0, 0, 0, 0, 0);
		add_pose(0, 0, 0, 0, 0, 0, 200000, -200000);
		add_pose(0, 0, 0, 0, 0, 16384, 65536, 0, 0, 1);
		add_pose(0, 0, 0, 0, 0, 16384, 65536, 0, 1, 0);
		add_pose(0, 0, 0, 0, 0, 16384, 65536, 0, 0, 0);
		add_pose(-1073741824, -1073741824, 0, 0, 0, 16384, 1073741823, 1073741823);
		add_pose(1073741823, 1073741823, 0, 0, 0, 16384, -1073741824, -1073741824);
		add_pose(1073741823, -1073741824, 0, 0, 0, 16384, -1073741824, 1073741823);
		add_pose(0, 0, -32768, -32768, -32768, -32768, 65536, 65536);
		add_pose(0, 0, 32767, 32767, 32767, 32767, -65536, 65536);
		add_pose(0, 0, 16384, -16384, 16384, -16384, 0, -65536);
		add_pose(0, 0, 0, 0, 11585, 11585, 100000, 0);
		add_pose(0, 0, 0, 0, 0, 16384, -100000, 1);
		add_pose(0, 0, 0, 0, 0, 16384, -100000, -1);
		add_pose(0, 0, 0, 0, 0, 16384, 16383, 0);
		add_pose(0, 0, 0, 0, 0, 16384, 16400, 0);
		drain();

		// extremes: everything at full scale, no arrive zone, no align slack
		write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 31'd0, 15'd0);
		reg_write(REG_UNUSED, 31'h7FFFFFFF);
		random_phase(300);

		// other extreme: zero gains and clamps, widest arrive zone
		write_all(16'd0, 16'd0, 16'd0, 16'd0, 31'h7FFFFFFF, 15'd25736);
		random_phase(150);

		// back-to-back ticks with a long receiver hold-off
		write_all(16'd3277, 16'd10240, 16'd8000, 16'd6000, 31'd4000, 15'd25736);
		send_gap_max = 0;
		recv_stall_max = 0;
		@(posedge clk);
		hold_req <= ~hold_req;
		random_phase(270);
		send_gap_max = 9;
		recv_stall_max = 9;

		for (int p = 0; p < 3; p++) begin
			write_all(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
				31'($urandom_range(0, 200000)), 15'($urandom_range(0, 25736)));
			random_phase(270);
		end

		while (cmd_q.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[go_to_goal_velocity_controller.f]
rtl/core/gtg_pkg.sv
rtl/core/gtg_if.sv
rtl/core/gtg_cordic_cell.sv
rtl/core/gtg_post.sv
rtl/core/go_to_goal_velocity_controller.sv
verif/tb_go_to_goal_velocity_controller.sv
